// ----- rtl/rwbp_pkg.sv -----
// ----------------------------------------------------------------------------
// rwbp_pkg
// Shared types and constants for the register word burst packer.
// ----------------------------------------------------------------------------
package rwbp_pkg;

    // reset value of the data tag register
    localparam logic [15:0] DATA_TAG_RESET = 16'h0F12;

    // default number of queued commands between front and back
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // byte positions inside one table word, most significant byte first
    localparam logic [1:0] BYTE_POS_TOP  = 2'd0;
    localparam logic [1:0] BYTE_POS_DATA = 2'd2;
    localparam logic [1:0] BYTE_POS_LAST = 2'd3;

    // one input item
    typedef struct packed {
        logic [31:0] table_word;
        logic        final_word;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       starts_transfer;
        logic       ends_table;
        logic       last;
    } t_out_item;

    // classified word queued for the byte serializer
    typedef struct packed {
        logic [31:0] word;
        logic        full_word;  // all four bytes, first one opens a transfer
        logic        final_word;
    } t_cmd;

endpackage

// ----- rtl/rwbp_front.sv -----
// ----------------------------------------------------------------------------
// rwbp_front
// Accepts table words, tracks burst state and classifies each word into a
// byte command for the serializer.
// ----------------------------------------------------------------------------
module rwbp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata,
    input  logic                i_valid,
    output logic                o_ready,
    input  rwbp_pkg::t_in_item  i_data,
    output logic                o_push,
    output rwbp_pkg::t_cmd      o_cmd,
    input  logic                i_full
);
    import rwbp_pkg::*;

    logic        r_burst_open, n_burst_open;
    logic        r_tag_sent, n_tag_sent;
    logic [15:0] r_data_tag;
    logic        w_accept;
    logic        w_is_data;

    // a transfer is taken whenever the queue has room
    assign o_ready  = !i_full;
    assign w_accept = i_valid && !i_full;

    // data word only once an address word has opened the burst
    assign w_is_data = r_burst_open && (i_data.table_word[31:16] == r_data_tag);

    // command for the serializer
    always_comb begin
        o_push           = w_accept;
        o_cmd.word       = i_data.table_word;
        o_cmd.full_word  = !w_is_data || !r_tag_sent;
        o_cmd.final_word = i_data.final_word;
    end

    // burst state update
    always_comb begin
        n_burst_open = r_burst_open;
        n_tag_sent   = r_tag_sent;
        if (w_accept) begin
            if (i_data.final_word) begin
                n_burst_open = 1'b0;
                n_tag_sent   = 1'b0;
            end else if (!w_is_data) begin
                n_burst_open = 1'b1;
                n_tag_sent   = 1'b0;
            end else begin
                n_tag_sent   = 1'b1;
            end
        end
    end

    // state and tag registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst_open <= 1'b0;
            r_tag_sent   <= 1'b0;
            r_data_tag   <= DATA_TAG_RESET;
        end else begin
            r_burst_open <= n_burst_open;
            r_tag_sent   <= n_tag_sent;
            if (i_cfg_we) begin
                r_data_tag <= i_cfg_wdata;
            end
        end
    end

endmodule

// ----- rtl/rwbp_queue.sv -----
// ----------------------------------------------------------------------------
// rwbp_queue
// Small command queue that decouples classification from serialization.
// ----------------------------------------------------------------------------
module rwbp_queue #(
    parameter int DEPTH = rwbp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rwbp_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_not_empty,
    output rwbp_pkg::t_cmd o_cmd
);
    import rwbp_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_cmd          r_entry [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full      = (r_count == CNT_FULL);
    assign o_not_empty = (r_count != '0);
    assign o_cmd       = r_entry[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ----- rtl/rwbp_back.sv -----
// ----------------------------------------------------------------------------
// rwbp_back
// Serializes queued commands into bus bytes, one byte per cycle while the
// output accepts, through an output register.
// ----------------------------------------------------------------------------
module rwbp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_not_empty,
    input  rwbp_pkg::t_cmd       i_cmd,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output rwbp_pkg::t_out_item  o_data
);
    import rwbp_pkg::*;

    logic      [1:0] r_pos, n_pos;
    logic            r_valid, n_valid;
    t_out_item       r_data, n_data;
    logic      [1:0] w_byte_pos;
    logic            w_load;

    // output register free or draining this cycle
    assign w_load = i_not_empty && (!r_valid || i_ready);

    // later data words skip the tag bytes
    assign w_byte_pos = i_cmd.full_word ? r_pos : r_pos + BYTE_POS_DATA;

    // byte select and flags
    always_comb begin
        case (w_byte_pos)
            BYTE_POS_TOP:  n_data.out_byte = i_cmd.word[31:24];
            2'd1:          n_data.out_byte = i_cmd.word[23:16];
            BYTE_POS_DATA: n_data.out_byte = i_cmd.word[15:8];
            default:       n_data.out_byte = i_cmd.word[7:0];
        endcase
        n_data.starts_transfer = i_cmd.full_word && (w_byte_pos == BYTE_POS_TOP);
        n_data.last            = (w_byte_pos == BYTE_POS_LAST);
        n_data.ends_table      = n_data.last && i_cmd.final_word;
    end

    // byte counter and output valid
    always_comb begin
        o_pop   = w_load && n_data.last;
        n_pos   = r_pos;
        n_valid = r_valid;
        if (o_pop) begin
            n_pos = '0;
        end else if (w_load) begin
            n_pos = r_pos + 1'b1;
        end
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_valid <= n_valid;
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

`ifndef SYNTHESIS
    // table end only ever on the closing byte of a word
    a_end_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_data.ends_table |-> r_data.last)
        else $error("ends_table without last");

    // a transfer opening byte is never the closing byte of a word
    a_start_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_data.starts_transfer |-> !r_data.last)
        else $error("starts_transfer on last byte");

    // queue entry released only together with its closing byte
    a_pop_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_valid && r_data.last && (r_pos == BYTE_POS_TOP))
        else $error("command popped before its last byte");

    // a word without tag bytes keeps its byte counter below the data byte position
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_not_empty && !i_cmd.full_word |-> r_pos != BYTE_POS_DATA &&
            r_pos != BYTE_POS_LAST)
        else $error("byte position out of range for data word");
`endif

endmodule

// ----- rtl/register_word_burst_packer_unit.sv -----
// ----------------------------------------------------------------------------
// register_word_burst_packer_unit
// Packs 32-bit register table words into bus write bytes with transfer marks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready, i_data) carries one table word and its
//   final_word flag per transfer. Output channel (o_valid/i_ready, o_data)
//   carries one byte per transfer with starts_transfer, ends_table and last.
//   An address word yields four bytes, the first data word of a burst four,
//   each later data word two. i_cfg_we/i_cfg_wdata write the 16-bit data tag;
//   write it only while the unit is idle.
//   Path: with the queue empty and the output free, a word is written into
//   a queue entry on its accept, and its first byte then into the output
//   register. Throughput: the serializer emits one byte per cycle while
//   i_ready is high; a command queue of QUEUE_DEPTH entries lets words be
//   taken back to back while bytes still drain.
//   Reset: synchronous active low; queue empty, burst state cleared, data tag
//   set to 0x0F12.
//   Stall: with i_ready low the held byte stays, the queue fills, and o_ready
//   drops once QUEUE_DEPTH words wait, the one being serialized included.
// ----------------------------------------------------------------------------
module register_word_burst_packer_unit #(
    parameter int QUEUE_DEPTH = rwbp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata,
    input  logic                i_valid,
    output logic                o_ready,
    input  rwbp_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output rwbp_pkg::t_out_item o_data
);
    import rwbp_pkg::*;

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_not_empty;
    t_cmd w_push_cmd;
    t_cmd w_head_cmd;

    // word classification
    rwbp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd),
        .i_full      (w_full)
    );

    // command queue
    rwbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_cmd       (w_push_cmd),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_not_empty (w_not_empty),
        .o_cmd       (w_head_cmd)
    );

    // byte serializer
    rwbp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_not_empty (w_not_empty),
        .i_cmd       (w_head_cmd),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

// ----- sim/register_word_burst_packer_unit_checker.sv -----
// ----------------------------------------------------------------------------
// register_word_burst_packer_unit_checker
// Watches the word and byte channels of the burst packer. It predicts the
// bytes each accepted table word must yield and compares every byte transfer
// against the oldest prediction. Mismatches are counted for the test top.
// ----------------------------------------------------------------------------
module register_word_burst_packer_unit_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  rwbp_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  rwbp_pkg::t_out_item i_out_data,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_byte_count
);

    timeunit 1ns;
    timeprecision 1ps;

    import rwbp_pkg::*;

    // shadow of the tag register and burst state
    logic [15:0] data_tag;
    logic        burst_open;
    logic        tag_sent;

    // bytes predicted but not yet seen on the output
    t_out_item   expected_bytes[$];
    int          fail_count = 0;
    int          byte_count = 0;
    int          pending = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;
    assign o_byte_count = byte_count;

    // queue the bytes one table word produces and advance the burst state
    task automatic pack_table_word(input t_in_item item);
        logic        is_data;
        int          first_pos;
        t_out_item   b;
        is_data = burst_open && (item.table_word[31:16] == data_tag);
        // address words and the first data word of a burst carry all four bytes
        first_pos = (!is_data || !tag_sent) ? int'(BYTE_POS_TOP) : int'(BYTE_POS_DATA);
        for (int pos = first_pos; pos <= int'(BYTE_POS_LAST); pos++) begin
            b.out_byte        = item.table_word[31 - 8 * pos -: 8];
            b.starts_transfer = (pos == int'(BYTE_POS_TOP));
            b.last            = (pos == int'(BYTE_POS_LAST));
            b.ends_table      = b.last && item.final_word;
            expected_bytes.push_back(b);
        end
        if (!is_data) begin
            burst_open = 1'b1;
            tag_sent   = 1'b0;
        end else begin
            tag_sent = 1'b1;
        end
        // a final word closes the table
        if (item.final_word) begin
            burst_open = 1'b0;
            tag_sent   = 1'b0;
        end
    endtask

    // predict on word transfers, compare on byte transfers
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            data_tag   = DATA_TAG_RESET;
            burst_open = 1'b0;
            tag_sent   = 1'b0;
            expected_bytes.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                pack_table_word(i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                byte_count++;
                if (expected_bytes.size() == 0) begin
                    $error("byte transfer with nothing expected: byte %h",
                           i_out_data.out_byte);
                    fail_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_out_data.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %h, actual %h",
                               want.out_byte, i_out_data.out_byte);
                        fail_count++;
                    end
                    if (i_out_data.starts_transfer !== want.starts_transfer) begin
                        $error("starts_transfer: expected %b, actual %b",
                               want.starts_transfer, i_out_data.starts_transfer);
                        fail_count++;
                    end
                    if (i_out_data.ends_table !== want.ends_table) begin
                        $error("ends_table: expected %b, actual %b",
                               want.ends_table, i_out_data.ends_table);
                        fail_count++;
                    end
                    if (i_out_data.last !== want.last) begin
                        $error("last: expected %b, actual %b",
                               want.last, i_out_data.last);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                data_tag = i_cfg_wdata;
            end
        end
        pending = expected_bytes.size();
    end

endmodule

// ----- sim/register_word_burst_packer_unit_test.sv -----
// ----------------------------------------------------------------------------
// register_word_burst_packer_unit_test
// Drives register table words into the burst packer under several data tag
// settings: a directed set of corner cases, then random tables made of
// address words and tagged bursts mixed with unstructured words. Both
// channels stall at random; the checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module register_word_burst_packer_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import rwbp_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_in_item    i_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out_item   o_data;

    int          fail_count;
    int          pending;
    int          byte_count;

    // stimulus bookkeeping
    logic [15:0] tag_now = DATA_TAG_RESET;
    logic        calm = 1'b0;
    int          words_sent = 0;
    int          tag_loads = 0;

    register_word_burst_packer_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

    register_word_burst_packer_unit_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_data   (o_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_byte_count (byte_count)
    );

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    // byte side: runs of ready broken by stall bursts, none once calm
    initial begin
        forever begin
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
            if (!calm && $urandom_range(0, 2) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
        end
    end

    // present one word and hold it until the transfer, then maybe go idle
    task automatic send_word(input logic [31:0] word, input logic fin);
        logic took;
        i_valid <= 1'b1;
        i_data  <= '{table_word: word, final_word: fin};
        do begin
            @(negedge i_clk);
            took = o_ready;
            @(posedge i_clk);
        end while (!took);
        words_sent++;
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    // hold off the word side until every predicted byte has come out
    task automatic drain();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic load_data_tag(input logic [15:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tag_now = value;
        tag_loads++;
    endtask

    // one well-formed table: address words, each followed by a tagged burst
    task automatic send_table();
        logic [31:0] words[$];
        logic [31:0] w;
        int          segs;
        int          s;
        segs = $urandom_range(1, 3);
        for (s = 0; s < segs; s++) begin
            w = $urandom;
            // a tagged first word still counts as an address word
            if (s == 0 && $urandom_range(0, 7) == 0) begin
                w[31:16] = tag_now;
            end else if (s > 0 && w[31:16] == tag_now) begin
                w[31:16] = ~tag_now;
            end
            words.push_back(w);
            repeat ($urandom_range(0, 6)) words.push_back({tag_now, 16'($urandom)});
        end
        foreach (words[i]) send_word(words[i], i == words.size() - 1);
    endtask

    // loose words: tagged or not, final at random, no table structure
    task automatic send_noise(input int count);
        logic [31:0] w;
        repeat (count) begin
            w = $urandom;
            if ($urandom_range(0, 2) == 0) w[31:16] = tag_now;
            send_word(w, $urandom_range(0, 5) == 0);
        end
    endtask

    task automatic run_phase(input logic [15:0] value, input int count);
        int stop_at;
        load_data_tag(value);
        stop_at = words_sent + count;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 4) == 0) send_noise($urandom_range(1, 6));
            else send_table();
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset tag: burst with extreme data, table end, tagged first word
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word({DATA_TAG_RESET, 16'hABCD}, 1'b0);
        send_word({DATA_TAG_RESET, 16'h0000}, 1'b0);
        send_word({DATA_TAG_RESET, 16'hFFFF}, 1'b1);
        send_word({DATA_TAG_RESET, 16'h1234}, 1'b0);
        send_word({DATA_TAG_RESET, 16'h5678}, 1'b0);
        // address word in the middle of a burst restarts the tag bytes
        send_word(32'h0000_0000, 1'b0);
        send_word({DATA_TAG_RESET, 16'h0001}, 1'b1);
        send_word(32'hA5A5_5A5A, 1'b1);
        send_word({DATA_TAG_RESET, 16'h8000}, 1'b1);
        send_word(32'h1234_5678, 1'b0);
        send_word({DATA_TAG_RESET, 16'h9999}, 1'b1);

        // tag extremes
        load_data_tag(16'h0000);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0000_FFFF, 1'b0);
        send_word(32'h0000_8001, 1'b1);
        load_data_tag(16'hFFFF);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'hFFFF_0000, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'hFFFF_1234, 1'b1);

        // random tables under several tag settings
        run_phase(DATA_TAG_RESET, 80);
        run_phase(16'h0000, 70);
        run_phase(16'hFFFF, 70);
        run_phase(16'($urandom), 80);
        run_phase(16'($urandom), 70);
        calm = 1'b1;
        run_phase(16'($urandom), 70);

        drain();
        repeat (16) @(posedge i_clk);

        $display("run covered %0d table words under %0d tag loads, %0d bytes checked",
                 words_sent, tag_loads, byte_count);
        $display("including tagged first words, mid-burst address words and one-word tables");
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
